FILE: rtl/fsus_pkg.sv
// Shared types and constants for the fair-share user scheduler.
`default_nettype none

package fsus_pkg;

    localparam int NUM_USERS_DEF   = 16;
    localparam int MAX_PENDING_DEF = 255;
    localparam int TIME_BITS_DEF   = 48;

    localparam logic [1:0] REQ_ENQUEUE  = 2'd0;
    localparam logic [1:0] REQ_CHARGE   = 2'd1;
    localparam logic [1:0] REQ_DISPATCH = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  user_index;
        logic [31:0] charge_time;
    } req_t;

    typedef struct packed {
        logic       granted;
        logic [3:0] granted_user;
        logic       rejected;
        logic       idle;
    } rsp_t;

    typedef enum logic {
        ALU_MAX,
        ALU_SATADD
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ_RD,
        ST_ENQ_UPD,
        ST_CHG_RD,
        ST_CHG_MAX,
        ST_CHG_ADD,
        ST_DSP_SCAN,
        ST_DSP_PICK,
        ST_DSP_ACT,
        ST_DSP_CHK,
        ST_RESP
    } fsus_state_t;

endpackage

`default_nettype wire

FILE: rtl/fsus_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fsus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wa,
    input  wire logic [WIDTH-1:0]         wd,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] ra,
    output logic      [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd <= mem[ra];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fsus_alu.sv
// Shared time unit: max or saturating add, with a compare of the two operands.
`default_nettype none

module fsus_alu #(
    parameter int WIDTH = 48
) (
    input  wire logic [WIDTH-1:0]      a,
    input  wire logic [WIDTH-1:0]      b,
    input  wire fsus_pkg::alu_op_t     op,
    output logic      [WIDTH-1:0]      y,
    output logic                       lt,
    output logic                       eq
);
    import fsus_pkg::*;

    logic [WIDTH:0] sum;

    always_comb
    begin
        lt  = (a < b);
        eq  = (a == b);
        sum = {1'b0, a} + {1'b0, b};
        case (op)
            ALU_MAX:    y = lt ? b : a;
            ALU_SATADD: y = sum[WIDTH] ? {WIDTH{1'b1}} : sum[WIDTH-1:0];
            default:    y = a;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/fair_share_user_scheduler_unit.sv
// Fair-share user scheduler: sequencer around one shared time unit and per-user RAMs.
// Unknown or out-of-range requests go straight to the response, which waits on the output stall.
// Dispatch: each search pass makes one key RAM read per user through the shared
// compare; at most 2*NUM_USERS + 1 passes. One transaction at a time.
// Reset (async, active low) clears all per-user state through written bits; no sweep.
`default_nettype none

module fair_share_user_scheduler_unit #(
    parameter int NUM_USERS   = fsus_pkg::NUM_USERS_DEF,
    parameter int MAX_PENDING = fsus_pkg::MAX_PENDING_DEF,
    parameter int TIME_BITS   = fsus_pkg::TIME_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire fsus_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output fsus_pkg::rsp_t      rsp
);
    import fsus_pkg::*;

    localparam int IDX_W  = $clog2(NUM_USERS);
    localparam int CNT_W  = $clog2(NUM_USERS + 1);
    localparam int PEND_W = $clog2(MAX_PENDING + 1);

    fsus_state_t state_reg, state_next;

    logic [3:0]           user_reg;
    logic [31:0]          charge_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;
    logic [IDX_W-1:0]     cand_idx_reg;
    logic                 cand_vld_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_key_reg;
    logic [TIME_BITS-1:0] act_reg;
    logic [PEND_W-1:0]    pend_reg;
    logic [TIME_BITS-1:0] baseline_reg;
    logic [NUM_USERS-1:0] active_reg;
    logic [NUM_USERS-1:0] key_wr_reg, exc_wr_reg, pend_wr_reg;
    logic                 key_ok_reg, exc_ok_reg, pend_ok_reg;
    rsp_t                 res_reg;
    rsp_t                 rsp_reg;
    logic                 rsp_valid_reg;

    logic                 key_re, key_we, exc_re, exc_we, pend_re, pend_we;
    logic [IDX_W-1:0]     key_ra, key_wa, exc_ra, exc_wa, pend_ra, pend_wa;
    logic [TIME_BITS-1:0] key_wd, exc_wd, key_rd, exc_rd;
    logic [PEND_W-1:0]    pend_wd, pend_rd;
    logic [TIME_BITS-1:0] key_m, exc_m;
    logic [PEND_W-1:0]    pend_m;

    logic [TIME_BITS-1:0] alu_a, alu_b, alu_y;
    alu_op_t              alu_op;
    logic                 alu_lt, alu_eq;

    logic                 accept;
    logic                 in_user_ok;
    logic [IDX_W-1:0]     user_addr;
    logic                 pend_full;
    logic                 scan_done;
    logic                 cand_better;
    logic                 rsp_load;

    fsus_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_USERS)) u_key_ram (
        .clk (clk), .we (key_we), .wa (key_wa), .wd (key_wd),
        .re  (key_re), .ra (key_ra), .rd (key_rd)
    );

    fsus_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_USERS)) u_exc_ram (
        .clk (clk), .we (exc_we), .wa (exc_wa), .wd (exc_wd),
        .re  (exc_re), .ra (exc_ra), .rd (exc_rd)
    );

    fsus_ram #(.WIDTH(PEND_W), .DEPTH(NUM_USERS)) u_pend_ram (
        .clk (clk), .we (pend_we), .wa (pend_wa), .wd (pend_wd),
        .re  (pend_re), .ra (pend_ra), .rd (pend_rd)
    );

    fsus_alu #(.WIDTH(TIME_BITS)) u_alu (
        .a (alu_a), .b (alu_b), .op (alu_op), .y (alu_y), .lt (alu_lt), .eq (alu_eq)
    );

    // entries never written read as zero
    assign key_m  = key_ok_reg  ? key_rd  : '0;
    assign exc_m  = exc_ok_reg  ? exc_rd  : '0;
    assign pend_m = pend_ok_reg ? pend_rd : '0;

    assign req_stall   = (state_reg != ST_IDLE);
    assign accept      = req_valid && !req_stall;
    assign in_user_ok  = (int'(req.user_index) < NUM_USERS);
    assign user_addr   = IDX_W'(user_reg);
    assign pend_full   = (pend_m >= PEND_W'(MAX_PENDING));
    assign scan_done   = (scan_cnt_reg == CNT_W'(NUM_USERS));
    assign cand_better = cand_vld_reg && active_reg[cand_idx_reg] && (!found_reg || alu_lt);
    assign rsp_load    = (state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_ENQUEUE:  state_next = in_user_ok ? ST_ENQ_RD : ST_RESP;
                        REQ_CHARGE:   state_next = in_user_ok ? ST_CHG_RD : ST_RESP;
                        REQ_DISPATCH: state_next = ST_DSP_SCAN;
                        default:      state_next = ST_RESP;
                    endcase
                end
            end
            ST_ENQ_RD:   state_next = ST_ENQ_UPD;
            ST_ENQ_UPD:  state_next = ST_RESP;
            ST_CHG_RD:   state_next = ST_CHG_MAX;
            ST_CHG_MAX:  state_next = ST_CHG_ADD;
            ST_CHG_ADD:  state_next = ST_RESP;
            ST_DSP_SCAN: state_next = scan_done ? ST_DSP_PICK : ST_DSP_SCAN;
            ST_DSP_PICK: state_next = found_reg ? ST_DSP_ACT : ST_RESP;
            ST_DSP_ACT:  state_next = ST_DSP_CHK;
            ST_DSP_CHK:
            begin
                // stale key or nothing pending: search again
                if (!alu_eq || (pend_reg == '0))
                begin
                    state_next = ST_DSP_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:     state_next = rsp_load ? ST_IDLE : ST_RESP;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        key_re  = 1'b0;
        key_ra  = '0;
        key_we  = 1'b0;
        key_wa  = '0;
        key_wd  = '0;
        exc_re  = 1'b0;
        exc_ra  = '0;
        exc_we  = 1'b0;
        exc_wa  = '0;
        exc_wd  = '0;
        pend_re = 1'b0;
        pend_ra = '0;
        pend_we = 1'b0;
        pend_wa = '0;
        pend_wd = '0;
        alu_a   = '0;
        alu_b   = '0;
        alu_op  = ALU_MAX;
        case (state_reg)
            ST_ENQ_RD:
            begin
                pend_re = 1'b1;
                pend_ra = user_addr;
            end
            ST_ENQ_UPD:
            begin
                if (!pend_full)
                begin
                    pend_we = 1'b1;
                    pend_wa = user_addr;
                    pend_wd = pend_m + PEND_W'(1);
                end
            end
            ST_CHG_RD:
            begin
                exc_re = 1'b1;
                exc_ra = user_addr;
            end
            ST_CHG_MAX:
            begin
                alu_a = exc_m;
                alu_b = baseline_reg;
            end
            ST_CHG_ADD:
            begin
                alu_a  = act_reg;
                alu_b  = TIME_BITS'(charge_reg);
                alu_op = ALU_SATADD;
                exc_we = 1'b1;
                exc_wa = user_addr;
                exc_wd = alu_y;
            end
            ST_DSP_SCAN:
            begin
                key_re = !scan_done;
                key_ra = scan_cnt_reg[IDX_W-1:0];
                alu_a  = key_m;
                alu_b  = best_key_reg;
            end
            ST_DSP_PICK:
            begin
                exc_re  = found_reg;
                exc_ra  = best_idx_reg;
                pend_re = found_reg;
                pend_ra = best_idx_reg;
            end
            ST_DSP_ACT:
            begin
                alu_a = exc_m;
                alu_b = baseline_reg;
            end
            ST_DSP_CHK:
            begin
                alu_a = best_key_reg;
                alu_b = act_reg;
                if (!alu_eq)
                begin
                    key_we = 1'b1;
                    key_wa = best_idx_reg;
                    key_wd = act_reg;
                end
                else if (pend_reg != '0)
                begin
                    pend_we = 1'b1;
                    pend_wa = best_idx_reg;
                    pend_wd = pend_reg - PEND_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            key_wr_reg    <= '0;
            exc_wr_reg    <= '0;
            pend_wr_reg   <= '0;
            baseline_reg  <= '0;
            scan_cnt_reg  <= '0;
            cand_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (key_we)
            begin
                key_wr_reg[key_wa] <= 1'b1;
            end
            if (exc_we)
            begin
                exc_wr_reg[exc_wa] <= 1'b1;
            end
            if (pend_we)
            begin
                pend_wr_reg[pend_wa] <= 1'b1;
            end
            if ((state_reg == ST_ENQ_UPD) && !pend_full)
            begin
                active_reg[user_addr] <= 1'b1;
            end
            if ((state_reg == ST_DSP_CHK) && alu_eq)
            begin
                if (pend_reg == '0)
                begin
                    active_reg[best_idx_reg] <= 1'b0;
                end
                else
                begin
                    baseline_reg <= act_reg;
                end
            end
            if (state_reg != ST_DSP_SCAN)
            begin
                scan_cnt_reg <= '0;
                cand_vld_reg <= 1'b0;
                if (state_next == ST_DSP_SCAN)
                begin
                    found_reg <= 1'b0;
                end
            end
            else
            begin
                scan_cnt_reg <= scan_done ? scan_cnt_reg : scan_cnt_reg + CNT_W'(1);
                cand_vld_reg <= !scan_done;
                if (cand_better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            user_reg     <= req.user_index;
            charge_reg   <= req.charge_time;
            res_reg      <= '0;
        end
        if (key_re)
        begin
            key_ok_reg <= key_wr_reg[key_ra];
        end
        if (exc_re)
        begin
            exc_ok_reg <= exc_wr_reg[exc_ra];
        end
        if (pend_re)
        begin
            pend_ok_reg <= pend_wr_reg[pend_ra];
        end
        if (state_reg == ST_DSP_SCAN)
        begin
            cand_idx_reg <= key_ra;
            if (cand_better)
            begin
                best_idx_reg <= cand_idx_reg;
                best_key_reg <= key_m;
            end
        end
        if ((state_reg == ST_CHG_MAX) || (state_reg == ST_DSP_ACT))
        begin
            act_reg <= alu_y;
        end
        if (state_reg == ST_DSP_ACT)
        begin
            pend_reg <= pend_m;
        end
        if (state_reg == ST_ENQ_UPD)
        begin
            res_reg.rejected <= pend_full;
        end
        if ((state_reg == ST_DSP_PICK) && !found_reg)
        begin
            res_reg.idle <= 1'b1;
        end
        if ((state_reg == ST_DSP_CHK) && alu_eq && (pend_reg != '0))
        begin
            res_reg.granted      <= 1'b1;
            res_reg.granted_user <= 4'(best_idx_reg);
        end
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_stall)
        else $error("request not stalled after accepted transaction");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($countones({rsp.granted, rsp.rejected, rsp.idle}) <= 1))
        else $error("response carries more than one outcome");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_we |-> (int'(pend_wd) <= MAX_PENDING))
        else $error("pending count written beyond limit");

    a_grant_active: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DSP_CHK) && alu_eq && (pend_reg != '0))
            |-> active_reg[best_idx_reg])
        else $error("grant to inactive user");
`endif

endmodule

`default_nettype wire

FILE: bench/fair_share_user_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fair-share user scheduler, with a fair queuing predictor.

import fsus_pkg::*;

class grant_scoreboard;
    typedef logic [TIME_BITS_DEF-1:0] usec_t;

    usec_t       excess   [NUM_USERS_DEF];
    usec_t       key      [NUM_USERS_DEF];
    int unsigned backlog  [NUM_USERS_DEF];
    bit          active   [NUM_USERS_DEF];
    usec_t       base;
    rsp_t        predicted_rsp [$];
    int          errors;

    function new();
        for (int i = 0; i < NUM_USERS_DEF; i++)
        begin
            excess[i]  = '0;
            key[i]     = '0;
            backlog[i] = 0;
            active[i]  = 1'b0;
        end
        base   = '0;
        errors = 0;
    endfunction

    function usec_t sat_add(usec_t a, logic [31:0] b);
        logic [TIME_BITS_DEF:0] sum;
        sum = a + b;
        return sum[TIME_BITS_DEF] ? '1 : sum[TIME_BITS_DEF-1:0];
    endfunction

    function usec_t served_time(int u);
        return (excess[u] > base) ? excess[u] : base;
    endfunction

    function int outstanding();
        return predicted_rsp.size();
    endfunction

    function void note_request(req_t r);
        rsp_t  e;
        int    best;
        int    pass;
        bit    found;
        bit    searching;
        usec_t act;
        e = '0;
        case (r.req_type)
            REQ_ENQUEUE:
            begin
                if (backlog[r.user_index] >= MAX_PENDING_DEF)
                    e.rejected = 1'b1;
                else
                begin
                    backlog[r.user_index]++;
                    active[r.user_index] = 1'b1;
                end
            end
            REQ_CHARGE:
                excess[r.user_index] = sat_add(served_time(r.user_index), r.charge_time);
            REQ_DISPATCH:
            begin
                searching = 1'b1;
                pass = 0;
                // every pass either refreshes a key, drops a user, grants, or finds no active user
                while (searching && pass < 2 * NUM_USERS_DEF + 2)
                begin
                    pass++;
                    found = 1'b0;
                    best  = 0;
                    for (int i = 0; i < NUM_USERS_DEF; i++)
                        if (active[i] && (!found || key[i] < key[best]))
                        begin
                            best  = i;
                            found = 1'b1;
                        end
                    if (!found)
                        searching = 1'b0;
                    else
                    begin
                        act = served_time(best);
                        if (key[best] != act)
                            key[best] = act;
                        else if (backlog[best] == 0)
                            active[best] = 1'b0;
                        else
                        begin
                            base = act;
                            backlog[best]--;
                            e.granted      = 1'b1;
                            e.granted_user = best[3:0];
                            searching      = 1'b0;
                        end
                    end
                end
                e.idle = !e.granted;
            end
            default:
                ;
        endcase
        predicted_rsp = {predicted_rsp, e};
    endfunction

    function void check_response(rsp_t got);
        rsp_t e;
        if (predicted_rsp.size() == 0)
        begin
            $error("response with none expected: %h", got);
            errors++;
            return;
        end
        e = predicted_rsp.pop_front();
        if (got.granted !== e.granted)
        begin
            $error("granted: expected %0d, actual %0d", e.granted, got.granted);
            errors++;
        end
        if (got.granted_user !== e.granted_user)
        begin
            $error("granted_user: expected %0d, actual %0d", e.granted_user, got.granted_user);
            errors++;
        end
        if (got.rejected !== e.rejected)
        begin
            $error("rejected: expected %0d, actual %0d", e.rejected, got.rejected);
            errors++;
        end
        if (got.idle !== e.idle)
        begin
            $error("idle: expected %0d, actual %0d", e.idle, got.idle);
            errors++;
        end
    endfunction
endclass

module fair_share_user_scheduler_unit_tb;
    localparam int         STALL_LIMIT = 20000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [3:0] FULL_USER   = 4'd7;
    localparam logic [3:0] SAT_USER    = 4'd9;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stuck_cycles   = 0;

    grant_scoreboard sb = new();

    fair_share_user_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("[fair_share_user_scheduler_unit] ERROR");
        $finish;
    end

    function automatic req_t make_req(logic [1:0] t, logic [3:0] u, logic [31:0] c);
        req_t r;
        r.req_type    = t;
        r.user_index  = u;
        r.charge_time = c;
        return r;
    endfunction

    function automatic req_t random_request(int span);
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 35)
            r.req_type = REQ_ENQUEUE;
        else if (pick < 60)
            r.req_type = REQ_CHARGE;
        else if (pick < 95)
            r.req_type = REQ_DISPATCH;
        else
            r.req_type = REQ_UNKNOWN;
        r.user_index = 4'($urandom_range(span - 1));
        case ($urandom_range(9))
            0:          r.charge_time = '0;
            1:          r.charge_time = '1;
            2, 3, 4, 5: r.charge_time = $urandom_range(2000);
            default:    r.charge_time = $urandom;
        endcase
        return r;
    endfunction

    // valid is only dropped when a gap is taken, so back-to-back transactions keep it high
    task automatic send_req(input req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        send_req(make_req(REQ_UNKNOWN, 4'hF, 32'hFFFF_FFFF));
        send_req(make_req(REQ_ENQUEUE, 4'd0, 32'hFFFF_FFFF));
        send_req(make_req(REQ_ENQUEUE, 4'd15, 32'd0));
        send_req(make_req(REQ_CHARGE, 4'd0, 32'hFFFF_FFFF));
        send_req(make_req(REQ_CHARGE, 4'd15, 32'd0));
        send_req(make_req(REQ_DISPATCH, 4'hF, 32'hFFFF_FFFF));
        send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        send_req(make_req(REQ_CHARGE, 4'd3, 32'd1));
        send_req(make_req(REQ_ENQUEUE, 4'd3, 32'd0));
        send_req(make_req(REQ_ENQUEUE, 4'd3, 32'd0));
        send_req(make_req(REQ_ENQUEUE, 4'd15, 32'd0));
        repeat (4) send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        send_req(make_req(REQ_CHARGE, 4'd15, 32'hFFFF_FFFF));
        send_req(make_req(REQ_CHARGE, 4'd15, 32'hFFFF_FFFF));
        send_req(make_req(REQ_ENQUEUE, 4'd0, 32'd0));
        send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        send_req(make_req(REQ_UNKNOWN, 4'd0, 32'd0));
        drain_responses();

        // fill one user's backlog past the limit
        for (int n = 0; n < MAX_PENDING_DEF + 3; n++)
            send_req(make_req(REQ_ENQUEUE, FULL_USER, $urandom));
        repeat (4) send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        repeat (2) send_req(make_req(REQ_ENQUEUE, FULL_USER, 32'd0));
        drain_responses();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            // alternate runs of 25 items crowd four users to force contention
            for (int n = 0; n < 320; n++)
                send_req(random_request(((n / 25) % 2 == 0) ? 4 : 16));
            drain_responses();
        end

        // push one account far ahead with maximum charges, then let the baseline follow it
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < 20; n++)
            send_req(make_req(REQ_CHARGE, SAT_USER, 32'hFFFF_FFFF));
        send_req(make_req(REQ_ENQUEUE, SAT_USER, 32'd0));
        repeat (3) send_req(make_req(REQ_DISPATCH, 4'd0, 32'd0));
        for (int n = 0; n < 40; n++)
            send_req(random_request(16));
        drain_responses();

        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[fair_share_user_scheduler_unit] OK");
        else
            $display("[fair_share_user_scheduler_unit] ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/fsus_pkg.sv
rtl/fsus_ram.sv
rtl/fsus_alu.sv
rtl/fair_share_user_scheduler_unit.sv
bench/fair_share_user_scheduler_unit_tb.sv
